FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/hmac_pkg.sv
// ----------------------------------------------------------------------------
// hmac_pkg
// shared constants and sha-256 helper functions for the hmac counter block
// ----------------------------------------------------------------------------
`default_nettype none

package hmac_pkg;

   localparam int KeyWords = 8;
   localparam int CsrIdxW  = 3;
   localparam logic [31:0] IpadWord = 32'h36363636;
   localparam logic [31:0] OpadWord = 32'h5c5c5c5c;
   localparam logic [31:0] PadBit   = 32'h80000000;
   localparam logic [31:0] InnerLen = 32'd576;
   localparam logic [31:0] OuterLen = 32'd768;

   typedef logic [31:0] word_type;
   typedef logic [255:0] hash_type;

   localparam hash_type InitHash = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic word_type round_k(input logic [5:0] t);
      word_type k;
      begin
         case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
         endcase
         return k;
      end
   endfunction

   function automatic word_type rotr(input word_type x, input int n);
      begin
         return (x >> n) | (x << (32 - n));
      end
   endfunction

endpackage

`default_nettype wire

FILE: rtl/hmac_sha256_counter.sv
// ----------------------------------------------------------------------------
// hmac_sha256_counter
// hmac-sha256 of a 64-bit counter under a zero-padded key of up to 64 bytes
// ----------------------------------------------------------------------------
// usage:
//   csr_* writes the eight 64-bit key words (index 0..7, big-endian bytes);
//     write only while the block is idle, other indexes are dropped
//   req_* takes one counter beat; req_tready is high only while idle
//   rsp_* delivers the 256-bit digest, digest_word_0 in the low bits
// operation:
//   one sha-256 round unit is shared over four compressions (inner key,
//   inner message, outer key, outer message), 64 rounds each plus a
//   chaining add per block; after the last add rsp_tvalid rises and
//   the block waits for the beat to be taken
// reset:
//   synchronous; key words clear to zero, sequencer goes idle, no beat pending
// stall:
//   the digest is held in its register with rsp_tvalid high until
//   rsp_tready; no new counter is taken meanwhile
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hmac_sha256_counter (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_we,
   input  wire logic [hmac_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [63:0]   csr_wdata,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [63:0]   req_tdata,   // counter_value
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [255:0]       rsp_tdata    // digest_word_0..digest_word_3
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_ADD   = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [1:0]  blk_ff, blk_in;      // which of the four blocks
   logic [63:0] key_ff [hmac_pkg::KeyWords];
   logic [63:0] msg_ff, msg_in;
   hmac_pkg::hash_type chain_ff, chain_in;   // running hash h0..h7
   hmac_pkg::hash_type work_ff, work_in;     // a..h
   hmac_pkg::hash_type inner_ff, inner_in;   // inner digest
   hmac_pkg::word_type sched_ff [16];
   hmac_pkg::word_type sched_in [16];
   hmac_pkg::word_type blk_w [16];

   // key words
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hmac_pkg::KeyWords; i++) key_ff[i] <= 64'h0;
      end else if (csr_we) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   // message block for the block about to start
   always_comb begin
      for (int i = 0; i < 16; i++) blk_w[i] = 32'h0;
      case (blk_in)
         2'd0, 2'd2: begin
            for (int i = 0; i < 8; i++) begin
               blk_w[2*i]   = key_ff[i][63:32] ^
                  ((blk_in == 2'd0) ? hmac_pkg::IpadWord : hmac_pkg::OpadWord);
               blk_w[2*i+1] = key_ff[i][31:0] ^
                  ((blk_in == 2'd0) ? hmac_pkg::IpadWord : hmac_pkg::OpadWord);
            end
         end
         2'd1: begin
            blk_w[0]  = msg_in[63:32];
            blk_w[1]  = msg_in[31:0];
            blk_w[2]  = hmac_pkg::PadBit;
            blk_w[15] = hmac_pkg::InnerLen;
         end
         default: begin
            for (int i = 0; i < 8; i++) blk_w[i] = inner_in[255-32*i -: 32];
            blk_w[8]  = hmac_pkg::PadBit;
            blk_w[15] = hmac_pkg::OuterLen;
         end
      endcase
   end

   // round unit
   hmac_pkg::word_type a, b, c, d, e, f, g, h, t1, t2, w_new, s0, s1;
   always_comb begin
      a = work_ff[255:224]; b = work_ff[223:192]; c = work_ff[191:160];
      d = work_ff[159:128]; e = work_ff[127:96];  f = work_ff[95:64];
      g = work_ff[63:32];   h = work_ff[31:0];
      t1 = h + (hmac_pkg::rotr(e, 6) ^ hmac_pkg::rotr(e, 11) ^ hmac_pkg::rotr(e, 25))
         + ((e & f) ^ (~e & g)) + hmac_pkg::round_k(rnd_ff) + sched_ff[0];
      t2 = (hmac_pkg::rotr(a, 2) ^ hmac_pkg::rotr(a, 13) ^ hmac_pkg::rotr(a, 22))
         + ((a & b) ^ (a & c) ^ (b & c));
      s0 = hmac_pkg::rotr(sched_ff[1], 7) ^ hmac_pkg::rotr(sched_ff[1], 18)
         ^ (sched_ff[1] >> 3);
      s1 = hmac_pkg::rotr(sched_ff[14], 17) ^ hmac_pkg::rotr(sched_ff[14], 19)
         ^ (sched_ff[14] >> 10);
      w_new = sched_ff[0] + s0 + sched_ff[9] + s1;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      blk_in   = blk_ff;
      msg_in   = msg_ff;
      chain_in = chain_ff;
      work_in  = work_ff;
      inner_in = inner_ff;
      for (int i = 0; i < 16; i++) sched_in[i] = sched_ff[i];
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               msg_in   = req_tdata;
               blk_in   = 2'd0;
               chain_in = hmac_pkg::InitHash;
               work_in  = hmac_pkg::InitHash;
               rnd_in   = 6'd0;
               for (int i = 0; i < 16; i++) sched_in[i] = blk_w[i];
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            work_in = {t1 + t2, a, b, c, d + t1, e, f, g};
            for (int i = 0; i < 15; i++) sched_in[i] = sched_ff[i+1];
            sched_in[15] = w_new;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = ST_ADD;
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++)
               chain_in[255-32*i -: 32] = chain_ff[255-32*i -: 32]
                  + work_ff[255-32*i -: 32];
            if (blk_ff == 2'd1) inner_in = chain_in;
            if (blk_ff == 2'd3) begin
               state_in = ST_OUT;
            end else begin
               blk_in = blk_ff + 2'd1;
               if (blk_ff == 2'd1) chain_in = hmac_pkg::InitHash;
               work_in = chain_in;
               for (int i = 0; i < 16; i++) sched_in[i] = blk_w[i];
               state_in = ST_ROUND;
            end
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= 6'd0;
         blk_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         blk_ff   <= blk_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff   <= msg_in;
      chain_ff <= chain_in;
      work_ff  <= work_in;
      inner_ff <= inner_in;
      for (int i = 0; i < 16; i++) sched_ff[i] <= sched_in[i];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   // digest word 0 = h0:h1 in the low 64 bits
   always_comb begin
      for (int j = 0; j < 4; j++)
         rsp_tdata[64*j +: 64] = chain_ff[255-64*j -: 64];
   end

   `ASSERT_CLK(a_ready_valid_excl, clock, reset, !(req_tready && rsp_tvalid), "ready with result")
   `ASSERT_CLK(a_round_only_busy, clock, reset, rnd_ff != 6'd0 |-> state_ff == ST_ROUND, "round off")
   `ASSERT_CLK(a_out_last_block, clock, reset, rsp_tvalid |-> (blk_ff == 2'd3), "early result")
   `ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> req_tready, "not idle after reset")

endmodule

`default_nettype wire
